@@ sv/pwl_one_minus_exp_eval_assert.svh @@
// Assertion macros used by the piecewise-linear evaluator line module.
`ifndef PWL_ONE_MINUS_EXP_EVAL_ASSERT_SVH
`define PWL_ONE_MINUS_EXP_EVAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PWL_OME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwl_ome assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PWL_OME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwl_ome assertion failed");

`endif

@@ sv/pwl_ome_pkg.sv @@
// Package: constants, register codes and shared types of the PWL evaluator.
`timescale 1ns / 1ps
package pwl_ome_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int X_W     = 32;
  localparam int IDX_W   = 10;
  localparam int COEF_W  = 18;
  localparam int VAL_W   = FRAC_BITS + 1;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [VAL_W-1:0] ONE_VAL  = VAL_W'(1 << FRAC_BITS);
  localparam int               HALF_VAL = 1 << (FRAC_BITS - 1);

  localparam logic [X_W-1:0]   INV_SPACING_RST = 32'd65536;
  localparam logic [X_W-1:0]   MAX_VAL_RST     = 32'd655360;
  localparam logic [IDX_W-1:0] LAST_INDEX_RST  = 10'd1023;

  typedef enum logic [1:0] {
    REG_INV_SPACING,
    REG_MAX_VAL,
    REG_LAST_INDEX
  } cfg_reg_idx_t;

  typedef struct packed {
    logic [X_W-1:0]   inv_spacing;
    logic [X_W-1:0]   max_val;
    logic [IDX_W-1:0] last_index;
  } cfg_regs_t;

endpackage

@@ sv/pwl_ome_cfg.sv @@
// APB-style configuration register file of the PWL evaluator.
`timescale 1ns / 1ps
module pwl_ome_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pwl_ome_pkg::PADDR_W-1:0]     paddr,
  input  logic [pwl_ome_pkg::PDATA_W-1:0]     pwdata,
  output logic [pwl_ome_pkg::PDATA_W-1:0]     prdata,
  output logic                                pready,
  output pwl_ome_pkg::cfg_regs_t              cfg
);

  pwl_ome_pkg::cfg_regs_t   cfg_r;
  pwl_ome_pkg::cfg_reg_idx_t reg_sel;
  logic                     wr_en;

  assign reg_sel = pwl_ome_pkg::cfg_reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_spacing <= pwl_ome_pkg::INV_SPACING_RST;
      cfg_r.max_val     <= pwl_ome_pkg::MAX_VAL_RST;
      cfg_r.last_index  <= pwl_ome_pkg::LAST_INDEX_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        pwl_ome_pkg::REG_INV_SPACING: cfg_r.inv_spacing <= pwdata;
        pwl_ome_pkg::REG_MAX_VAL:     cfg_r.max_val     <= pwdata;
        pwl_ome_pkg::REG_LAST_INDEX:  cfg_r.last_index  <= pwdata[pwl_ome_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      pwl_ome_pkg::REG_INV_SPACING: prdata = cfg_r.inv_spacing;
      pwl_ome_pkg::REG_MAX_VAL:     prdata = cfg_r.max_val;
      pwl_ome_pkg::REG_LAST_INDEX:  prdata = pwl_ome_pkg::PDATA_W'(cfg_r.last_index);
      default:                      prdata = '0;
    endcase
  end

endmodule

@@ sv/pwl_ome_index.sv @@
// Input register, x times reciprocal spacing and domain compare (stages 1-2).
`timescale 1ns / 1ps
module pwl_ome_index (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  pwl_ome_pkg::cfg_regs_t                  cfg,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_wr,
  input  logic [pwl_ome_pkg::X_W-1:0]             in_x,
  input  logic [pwl_ome_pkg::IDX_W-1:0]           in_widx,
  input  logic signed [pwl_ome_pkg::COEF_W-1:0]   in_slope,
  input  logic signed [pwl_ome_pkg::COEF_W-1:0]   in_icpt,
  output logic                                    s2_valid,
  input  logic                                    s2_ready,
  output logic                                    s2_wr,
  output logic [pwl_ome_pkg::X_W-1:0]             s2_x,
  output logic [2*pwl_ome_pkg::X_W-1:0]           s2_prod,
  output logic                                    s2_above,
  output logic [pwl_ome_pkg::IDX_W-1:0]           s2_widx,
  output logic signed [pwl_ome_pkg::COEF_W-1:0]   s2_slope,
  output logic signed [pwl_ome_pkg::COEF_W-1:0]   s2_icpt
);

  localparam int XW = pwl_ome_pkg::X_W;

  logic                                  s1_valid_r, s2_valid_r;
  logic                                  s1_wr_r, s2_wr_r;
  logic [XW-1:0]                         s1_x_r, s2_x_r;
  logic [pwl_ome_pkg::IDX_W-1:0]         s1_widx_r, s2_widx_r;
  logic signed [pwl_ome_pkg::COEF_W-1:0] s1_slope_r, s2_slope_r;
  logic signed [pwl_ome_pkg::COEF_W-1:0] s1_icpt_r, s2_icpt_r;
  logic [2*XW-1:0]                       s2_prod_r, s2_prod_nxt;
  logic                                  s2_above_r, s2_above_nxt;
  logic                                  s2_load;

  assign s2_load  = !s2_valid_r || s2_ready;
  assign in_ready = !s1_valid_r || s2_load;

  assign s2_prod_nxt  = s1_x_r * cfg.inv_spacing;
  assign s2_above_nxt = s1_x_r > cfg.max_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s2_load)  s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_wr_r    <= in_wr;
      s1_x_r     <= in_x;
      s1_widx_r  <= in_widx;
      s1_slope_r <= in_slope;
      s1_icpt_r  <= in_icpt;
    end
    if (s2_load && s1_valid_r) begin
      s2_wr_r    <= s1_wr_r;
      s2_x_r     <= s1_x_r;
      s2_widx_r  <= s1_widx_r;
      s2_slope_r <= s1_slope_r;
      s2_icpt_r  <= s1_icpt_r;
      s2_prod_r  <= s2_prod_nxt;
      s2_above_r <= s2_above_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_wr    = s2_wr_r;
  assign s2_x     = s2_x_r;
  assign s2_prod  = s2_prod_r;
  assign s2_above = s2_above_r;
  assign s2_widx  = s2_widx_r;
  assign s2_slope = s2_slope_r;
  assign s2_icpt  = s2_icpt_r;

endmodule

@@ sv/pwl_ome_table.sv @@
// Segment index rounding and clamp, segment memory write and read (stage 3).
`timescale 1ns / 1ps
module pwl_ome_table #(
  parameter int TABLE_DEPTH = pwl_ome_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  pwl_ome_pkg::cfg_regs_t                  cfg,
  input  logic                                    s2_valid,
  output logic                                    s2_ready,
  input  logic                                    s2_wr,
  input  logic [pwl_ome_pkg::X_W-1:0]             s2_x,
  input  logic [2*pwl_ome_pkg::X_W-1:0]           s2_prod,
  input  logic                                    s2_above,
  input  logic [pwl_ome_pkg::IDX_W-1:0]           s2_widx,
  input  logic signed [pwl_ome_pkg::COEF_W-1:0]   s2_slope,
  input  logic signed [pwl_ome_pkg::COEF_W-1:0]   s2_icpt,
  output logic                                    s3_valid,
  input  logic                                    s3_ready,
  output logic [pwl_ome_pkg::X_W-1:0]             s3_x,
  output logic                                    s3_above,
  output logic signed [pwl_ome_pkg::COEF_W-1:0]   s3_slope,
  output logic signed [pwl_ome_pkg::COEF_W-1:0]   s3_icpt
);

  localparam int F      = pwl_ome_pkg::FRAC_BITS;
  localparam int XW     = pwl_ome_pkg::X_W;
  localparam int IW     = pwl_ome_pkg::IDX_W;
  localparam int CW     = pwl_ome_pkg::COEF_W;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  // product keeps one bit below the integer point for round-to-nearest
  localparam int RND_W  = 2*XW - (2*F - 1) + 1;
  localparam logic [16:0] LAST_ADDR = 17'(TABLE_DEPTH - 1);
  localparam logic [16:0] DEPTH_17  = 17'(TABLE_DEPTH);

  logic signed [CW-1:0] slope_mem [TABLE_DEPTH];
  logic signed [CW-1:0] icpt_mem  [TABLE_DEPTH];

  logic                 s3_valid_r;
  logic [XW-1:0]        s3_x_r;
  logic                 s3_above_r;
  logic signed [CW-1:0] s3_slope_r, s3_icpt_r;

  logic [RND_W-1:0]     rnd_sum;
  logic [RND_W-2:0]     seg_idx;
  logic [IW-1:0]        seg_lim;
  logic [16:0]          seg_17, seg_clamp, widx_17;
  logic [ADDR_W-1:0]    raddr, waddr;
  logic                 wr_en, rd_en;

  assign s2_ready = !s3_valid_r || s3_ready;

  // index = floor(prod / 2^(2F) + 1/2), then clamp to last_index and depth
  assign rnd_sum = {1'b0, s2_prod[2*XW-1:2*F-1]} + RND_W'(1);
  assign seg_idx = rnd_sum[RND_W-1:1];
  assign seg_lim = (seg_idx > (RND_W-1)'(cfg.last_index)) ? cfg.last_index
                                                          : seg_idx[IW-1:0];
  assign seg_17    = 17'(seg_lim);
  assign seg_clamp = (seg_17 > LAST_ADDR) ? LAST_ADDR : seg_17;
  assign raddr     = seg_clamp[ADDR_W-1:0];

  assign widx_17 = 17'(s2_widx);
  assign waddr   = widx_17[ADDR_W-1:0];
  assign wr_en   = s2_valid && s2_ready && s2_wr && (widx_17 < DEPTH_17);
  assign rd_en   = s2_valid && s2_ready && !s2_wr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slope_mem[waddr] <= s2_slope;
      icpt_mem[waddr]  <= s2_icpt;
    end
    if (rd_en) begin
      s3_slope_r <= slope_mem[raddr];
      s3_icpt_r  <= icpt_mem[raddr];
      s3_x_r     <= s2_x;
      s3_above_r <= s2_above;
    end
  end

  // write words end here; only evaluate words move on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s3_valid_r <= s2_valid && !s2_wr;
    end
  end

  assign s3_valid = s3_valid_r;
  assign s3_x     = s3_x_r;
  assign s3_above = s3_above_r;
  assign s3_slope = s3_slope_r;
  assign s3_icpt  = s3_icpt_r;

endmodule

@@ sv/pwl_ome_line.sv @@
// Line evaluation slope*x+intercept, rounding, saturation and output register.
`timescale 1ns / 1ps
`include "pwl_one_minus_exp_eval_assert.svh"
module pwl_ome_line (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    s3_valid,
  output logic                                    s3_ready,
  input  logic [pwl_ome_pkg::X_W-1:0]             s3_x,
  input  logic                                    s3_above,
  input  logic signed [pwl_ome_pkg::COEF_W-1:0]   s3_slope,
  input  logic signed [pwl_ome_pkg::COEF_W-1:0]   s3_icpt,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [pwl_ome_pkg::VAL_W-1:0]           out_value,
  output logic                                    out_above
);

  localparam int F      = pwl_ome_pkg::FRAC_BITS;
  localparam int XW     = pwl_ome_pkg::X_W;
  localparam int CW     = pwl_ome_pkg::COEF_W;
  localparam int VW     = pwl_ome_pkg::VAL_W;
  localparam int PROD_W = CW + XW + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int Q_W    = SUM_W - F;

  logic                     s4_valid_r, s5_valid_r, s6_valid_r;
  logic                     s4_above_r, s5_above_r, s6_above_r;
  logic signed [PROD_W-1:0] s4_prod_r, s4_prod_nxt;
  logic signed [CW-1:0]     s4_icpt_r;
  logic signed [SUM_W-1:0]  s5_sum_r, s5_sum_nxt;
  logic signed [SUM_W-1:0]  icpt_ext;
  logic [VW-1:0]            s6_value_r, s6_value_nxt;
  logic [SUM_W-1:0]         rnd;
  logic [Q_W-1:0]           rq;
  logic                     sum_pos;
  logic                     s4_load, s5_load, s6_load;

  assign s6_load  = !s6_valid_r || out_ready;
  assign s5_load  = !s5_valid_r || s6_load;
  assign s4_load  = !s4_valid_r || s5_load;
  assign s3_ready = s4_load;

  assign s4_prod_nxt = s3_slope * $signed({1'b0, s3_x});
  assign icpt_ext    = {{(SUM_W-CW-F){s4_icpt_r[CW-1]}}, s4_icpt_r, {F{1'b0}}};
  assign s5_sum_nxt  = {s4_prod_r[PROD_W-1], s4_prod_r} + icpt_ext;

  assign sum_pos = !s5_sum_r[SUM_W-1] && (s5_sum_r != '0);
  assign rnd     = $unsigned(s5_sum_r) + SUM_W'(pwl_ome_pkg::HALF_VAL);
  assign rq      = rnd[SUM_W-1:F];

  always_comb begin
    priority if (s5_above_r) begin
      s6_value_nxt = pwl_ome_pkg::ONE_VAL;
    end else if (!sum_pos) begin
      s6_value_nxt = '0;
    end else if (rq > Q_W'(pwl_ome_pkg::ONE_VAL)) begin
      s6_value_nxt = pwl_ome_pkg::ONE_VAL;
    end else begin
      s6_value_nxt = rq[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else begin
      if (s4_load) s4_valid_r <= s3_valid;
      if (s5_load) s5_valid_r <= s4_valid_r;
      if (s6_load) s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_load && s3_valid) begin
      s4_prod_r  <= s4_prod_nxt;
      s4_icpt_r  <= s3_icpt;
      s4_above_r <= s3_above;
    end
    if (s5_load && s4_valid_r) begin
      s5_sum_r   <= s5_sum_nxt;
      s5_above_r <= s4_above_r;
    end
    if (s6_load && s5_valid_r) begin
      s6_value_r <= s6_value_nxt;
      s6_above_r <= s5_above_r;
    end
  end

  assign out_valid = s6_valid_r;
  assign out_value = s6_value_r;
  assign out_above = s6_above_r;

  `PWL_OME_ASSERT_NOW(a_value_range, clk, rst_n, s6_valid_r, s6_value_r <= pwl_ome_pkg::ONE_VAL)
  `PWL_OME_ASSERT_NOW(a_above_is_one, clk, rst_n, s6_valid_r && s6_above_r, s6_value_r == pwl_ome_pkg::ONE_VAL)
  `PWL_OME_ASSERT_NEXT(a_s5_held, clk, rst_n, s5_valid_r && s6_valid_r && !out_ready, s5_valid_r && s6_valid_r)

endmodule

@@ sv/pwl_one_minus_exp_eval.sv @@
// Top level of the piecewise-linear 1-exp(-x) evaluator.
`timescale 1ns / 1ps
// Usage:
//  in_* stream carries request words. tuser = req_type: 0 evaluates at x,
//  1 writes slope/intercept of segment entry_index (no result word).
//  out_* stream returns one word per evaluate: value (Q1.16, 0..1.0) in
//  tdata, above_max in tuser.
//  cfg_* APB port: inv_spacing at 0x0, max_val at 0x4, last_index at 0x8.
//  Write registers only while the pipeline is empty.
// Timing:
//  Six register stages: input, x*inv_spacing multiply, segment memory read,
//  slope*x multiply, intercept add, round/saturate output register. Each word
//  moves through them in that order; one word per cycle sustained while
//  out_tready stays high, set by the single-port segment memory (one write or
//  one read per cycle) and the two multipliers, each fully pipelined.
// Reset: clears valid bits and loads the register defaults; the segment
//  table is not cleared and must be written before an entry is used.
// Stall: every stage holds its word while the next is full and cannot move on;
//  in_tready drops only once all six stages hold words and out_tready is low.
module pwl_one_minus_exp_eval #(
  parameter int TABLE_DEPTH = pwl_ome_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] x, [41:32] entry_index, [59:42] slope, [77:60] intercept
  input  logic [79:0]                       in_tdata,
  // [0] req_type
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [16:0] value
  output logic [23:0]                       out_tdata,
  // [0] above_max
  output logic [0:0]                        out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pwl_ome_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [pwl_ome_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [pwl_ome_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int XW = pwl_ome_pkg::X_W;
  localparam int IW = pwl_ome_pkg::IDX_W;
  localparam int CW = pwl_ome_pkg::COEF_W;
  localparam int VW = pwl_ome_pkg::VAL_W;

  pwl_ome_pkg::cfg_regs_t cfg;

  logic                 s2_valid, s2_ready, s2_wr, s2_above;
  logic [XW-1:0]        s2_x;
  logic [2*XW-1:0]      s2_prod;
  logic [IW-1:0]        s2_widx;
  logic signed [CW-1:0] s2_slope, s2_icpt;

  logic                 s3_valid, s3_ready, s3_above;
  logic [XW-1:0]        s3_x;
  logic signed [CW-1:0] s3_slope, s3_icpt;

  logic [VW-1:0]        out_value;
  logic                 out_above;

  pwl_ome_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pwl_ome_index u_index (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_wr    (in_tuser[0]),
    .in_x     (in_tdata[31:0]),
    .in_widx  (in_tdata[41:32]),
    .in_slope ($signed(in_tdata[59:42])),
    .in_icpt  ($signed(in_tdata[77:60])),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_wr    (s2_wr),
    .s2_x     (s2_x),
    .s2_prod  (s2_prod),
    .s2_above (s2_above),
    .s2_widx  (s2_widx),
    .s2_slope (s2_slope),
    .s2_icpt  (s2_icpt)
  );

  pwl_ome_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_wr    (s2_wr),
    .s2_x     (s2_x),
    .s2_prod  (s2_prod),
    .s2_above (s2_above),
    .s2_widx  (s2_widx),
    .s2_slope (s2_slope),
    .s2_icpt  (s2_icpt),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .s3_x     (s3_x),
    .s3_above (s3_above),
    .s3_slope (s3_slope),
    .s3_icpt  (s3_icpt)
  );

  pwl_ome_line u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_valid  (s3_valid),
    .s3_ready  (s3_ready),
    .s3_x      (s3_x),
    .s3_above  (s3_above),
    .s3_slope  (s3_slope),
    .s3_icpt   (s3_icpt),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_value),
    .out_above (out_above)
  );

  assign out_tdata = {{(24-VW){1'b0}}, out_value};
  assign out_tuser = out_above;

endmodule
